/* hw/rtl/cxy_pkg.sv */
// ----------------------------------------------------------------------------
// cxy_pkg
// Codes, constants and shared helpers of the CoreXY motion command controller.
// ----------------------------------------------------------------------------
package cxy_pkg;

	localparam int FEED_BITS = 16;

	// command codes
	localparam logic [1:0] FUNC_MOVE = 2'd0;
	localparam logic [1:0] FUNC_HOME = 2'd1;
	localparam logic [1:0] FUNC_DONE = 2'd2;
	localparam logic [1:0] FUNC_STOP = 2'd3;

	// controller modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_MOVING = 3'd1;
	localparam logic [2:0] MODE_HOME_Z = 3'd2;
	localparam logic [2:0] MODE_HOME_X = 3'd3;
	localparam logic [2:0] MODE_HOME_Y = 3'd4;

	// result status
	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_BUSY   = 2'd1;
	localparam logic [1:0] ST_OOB    = 2'd2;

	// homing start command
	localparam logic [1:0] HM_NONE = 2'd0;
	localparam logic [1:0] HM_A    = 2'd1;
	localparam logic [1:0] HM_B    = 2'd2;
	localparam logic [1:0] HM_Z    = 2'd3;

	// finished motor select
	localparam logic [1:0] MSEL_A    = 2'd0;
	localparam logic [1:0] MSEL_B    = 2'd1;
	localparam logic [1:0] MSEL_Z    = 2'd2;
	localparam logic [1:0] MSEL_NONE = 2'd3;

	localparam logic [2:0] FLAGS_ALL = 3'b111;

	// register map indexes
	localparam logic [2:0] REG_REL   = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MAX_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Z = 3'd3;
	localparam logic [2:0] REG_SPM_A = 3'd4;
	localparam logic [2:0] REG_SPM_B = 3'd5;
	localparam logic [2:0] REG_SPM_Z = 3'd6;

	localparam int MAX_XY_RESET = 56320;
	localparam int MAX_Z_RESET  = 64000;
	localparam int SPM_XY_RESET = 80;
	localparam int SPM_Z_RESET  = 400;
	localparam logic [FEED_BITS-1:0] FEED_RESET = 16'd1000;

	typedef struct packed {
		logic [2:0] mode;
		logic [1:0] hm;
		logic [2:0] pend;
	} home_step_t;

	// pick the next axis to home, Z first, then X, then Y
	function automatic home_step_t next_home(input logic [2:0] pend);
		home_step_t r;
		r.pend = pend;
		r.mode = MODE_IDLE;
		r.hm   = HM_NONE;
		if (pend[2]) begin
			r.pend[2] = 1'b0;
			r.mode    = MODE_HOME_Z;
			r.hm      = HM_Z;
		end else if (pend[0]) begin
			r.pend[0] = 1'b0;
			r.mode    = MODE_HOME_X;
			r.hm      = HM_A;
		end else if (pend[1]) begin
			r.pend[1] = 1'b0;
			r.mode    = MODE_HOME_Y;
			r.hm      = HM_B;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/cxy_if.sv */
// ----------------------------------------------------------------------------
// cxy_cmd_if / cxy_res_if
// Valid/ready channels carrying commands into and results out of the block.
// ----------------------------------------------------------------------------
interface cxy_cmd_if #(
	parameter int COORD_BITS = 23
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            func;
	logic signed [COORD_BITS:0] coord_x;
	logic signed [COORD_BITS:0] coord_y;
	logic signed [COORD_BITS:0] coord_z;
	logic [2:0]            axis_mask;
	logic [15:0]           feedrate;
	logic [1:0]            motor_sel;
	logic                  motor_ok;

	modport source (
		output valid, func, coord_x, coord_y, coord_z, axis_mask, feedrate,
			motor_sel, motor_ok,
		input  ready
	);
	modport sink (
		input  valid, func, coord_x, coord_y, coord_z, axis_mask, feedrate,
			motor_sel, motor_ok,
		output ready
	);
endinterface

interface cxy_res_if #(
	parameter int COORD_BITS = 23,
	parameter int SPM_BITS   = 12
);
	localparam int STEP_BITS = COORD_BITS + SPM_BITS - 6;
	localparam int RATE_BITS = SPM_BITS + 11;

	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [2:0]                  ctrl_state;
	logic signed [STEP_BITS-1:0] steps_a;
	logic signed [STEP_BITS-1:0] steps_b;
	logic signed [STEP_BITS-1:0] steps_z;
	logic [RATE_BITS-1:0]        rate_a;
	logic [RATE_BITS-1:0]        rate_b;
	logic [RATE_BITS-1:0]        rate_z;
	logic [1:0]                  home_motor;
	logic                        stop_all;
	logic                        complete;
	logic                        complete_ok;

	modport source (
		output valid, status, ctrl_state, steps_a, steps_b, steps_z, rate_a,
			rate_b, rate_z, home_motor, stop_all, complete, complete_ok,
		input  ready
	);
	modport sink (
		input  valid, status, ctrl_state, steps_a, steps_b, steps_z, rate_a,
			rate_b, rate_z, home_motor, stop_all, complete, complete_ok,
		output ready
	);
endinterface

/* hw/rtl/cxy_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cxy_cfg_regs
// APB register bank: move mode, axis bounds and motor steps per mm.
// ----------------------------------------------------------------------------
module cxy_cfg_regs
	import cxy_pkg::*;
#(
	parameter int COORD_BITS = 23,
	parameter int SPM_BITS   = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [4:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic                  relative_mode,
	output logic [COORD_BITS-1:0] max_x,
	output logic [COORD_BITS-1:0] max_y,
	output logic [COORD_BITS-1:0] max_z,
	output logic [SPM_BITS-1:0]   spm_a,
	output logic [SPM_BITS-1:0]   spm_b,
	output logic [SPM_BITS-1:0]   spm_z
);

	logic                  rel_q;
	logic [COORD_BITS-1:0] max_x_q, max_y_q, max_z_q;
	logic [SPM_BITS-1:0]   spm_a_q, spm_b_q, spm_z_q;
	logic                  wr_en;
	logic [2:0]            idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_q   <= 1'b0;
			max_x_q <= COORD_BITS'(MAX_XY_RESET);
			max_y_q <= COORD_BITS'(MAX_XY_RESET);
			max_z_q <= COORD_BITS'(MAX_Z_RESET);
			spm_a_q <= SPM_BITS'(SPM_XY_RESET);
			spm_b_q <= SPM_BITS'(SPM_XY_RESET);
			spm_z_q <= SPM_BITS'(SPM_Z_RESET);
		end else if (wr_en) begin
			case (idx)
				REG_REL:   rel_q   <= pwdata[0];
				REG_MAX_X: max_x_q <= pwdata[COORD_BITS-1:0];
				REG_MAX_Y: max_y_q <= pwdata[COORD_BITS-1:0];
				REG_MAX_Z: max_z_q <= pwdata[COORD_BITS-1:0];
				REG_SPM_A: spm_a_q <= pwdata[SPM_BITS-1:0];
				REG_SPM_B: spm_b_q <= pwdata[SPM_BITS-1:0];
				REG_SPM_Z: spm_z_q <= pwdata[SPM_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_REL:   prdata = 32'(rel_q);
			REG_MAX_X: prdata = 32'(max_x_q);
			REG_MAX_Y: prdata = 32'(max_y_q);
			REG_MAX_Z: prdata = 32'(max_z_q);
			REG_SPM_A: prdata = 32'(spm_a_q);
			REG_SPM_B: prdata = 32'(spm_b_q);
			REG_SPM_Z: prdata = 32'(spm_z_q);
			default:   prdata = '0;
		endcase
	end

	assign relative_mode = rel_q;
	assign max_x = max_x_q;
	assign max_y = max_y_q;
	assign max_z = max_z_q;
	assign spm_a = spm_a_q;
	assign spm_b = spm_b_q;
	assign spm_z = spm_z_q;

endmodule

/* hw/rtl/cxy_cmd_stage.sv */
// ----------------------------------------------------------------------------
// cxy_cmd_stage
// Input register: captures a request, tracks the feedrate in force and forms
// the feed-times-steps-per-mm products for the rate dividers.
// ----------------------------------------------------------------------------
module cxy_cmd_stage
	import cxy_pkg::*;
#(
	parameter int COORD_BITS = 23,
	parameter int SPM_BITS   = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	cxy_cmd_if.sink                    cmd,
	input  logic [SPM_BITS-1:0]        spm_a,
	input  logic [SPM_BITS-1:0]        spm_b,
	input  logic [SPM_BITS-1:0]        spm_z,
	input  logic                       advance,
	output logic                       valid_s1,
	output logic [1:0]                 func_s1,
	output logic signed [COORD_BITS:0] coord_x_s1,
	output logic signed [COORD_BITS:0] coord_y_s1,
	output logic signed [COORD_BITS:0] coord_z_s1,
	output logic [2:0]                 mask_s1,
	output logic [1:0]                 sel_s1,
	output logic                       ok_s1,
	output logic [FEED_BITS+SPM_BITS-1:0] prod_a_s1,
	output logic [FEED_BITS+SPM_BITS-1:0] prod_b_s1,
	output logic [FEED_BITS+SPM_BITS-1:0] prod_z_s1
);

	localparam int FW = FEED_BITS + SPM_BITS;

	logic [FEED_BITS-1:0] feed_q;
	logic [FEED_BITS-1:0] feed_nxt;
	logic                 accept;

	assign cmd.ready = !valid_s1 || advance;
	assign accept    = cmd.valid && cmd.ready;

	// a nonzero feedrate on any move replaces the one in force
	assign feed_nxt = (cmd.func == FUNC_MOVE && cmd.feedrate != '0) ? cmd.feedrate : feed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			feed_q   <= FEED_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				feed_q   <= feed_nxt;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= cmd.func;
			coord_x_s1 <= cmd.coord_x;
			coord_y_s1 <= cmd.coord_y;
			coord_z_s1 <= cmd.coord_z;
			mask_s1    <= cmd.axis_mask;
			sel_s1     <= cmd.motor_sel;
			ok_s1      <= cmd.motor_ok;
			prod_a_s1  <= FW'(feed_nxt) * FW'(spm_a);
			prod_b_s1  <= FW'(feed_nxt) * FW'(spm_b);
			prod_z_s1  <= FW'(feed_nxt) * FW'(spm_z);
		end
	end

endmodule

/* hw/rtl/cxy_exec.sv */
// ----------------------------------------------------------------------------
// cxy_exec
// Command execution: target and bounds check, CoreXY step counts, step rates,
// move and homing sequencing, and the result register.
// ----------------------------------------------------------------------------
module cxy_exec
	import cxy_pkg::*;
#(
	parameter int COORD_BITS = 23,
	parameter int SPM_BITS   = 12
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  logic [1:0]                 func_s1,
	input  logic signed [COORD_BITS:0] coord_x_s1,
	input  logic signed [COORD_BITS:0] coord_y_s1,
	input  logic signed [COORD_BITS:0] coord_z_s1,
	input  logic [2:0]                 mask_s1,
	input  logic [1:0]                 sel_s1,
	input  logic                       ok_s1,
	input  logic [FEED_BITS+SPM_BITS-1:0] prod_a_s1,
	input  logic [FEED_BITS+SPM_BITS-1:0] prod_b_s1,
	input  logic [FEED_BITS+SPM_BITS-1:0] prod_z_s1,
	input  logic                       relative_mode,
	input  logic [COORD_BITS-1:0]      max_x,
	input  logic [COORD_BITS-1:0]      max_y,
	input  logic [COORD_BITS-1:0]      max_z,
	input  logic [SPM_BITS-1:0]        spm_a,
	input  logic [SPM_BITS-1:0]        spm_b,
	input  logic [SPM_BITS-1:0]        spm_z,
	output logic                       advance,
	cxy_res_if.source                  res
);

	localparam int STEP_BITS = COORD_BITS + SPM_BITS - 6;
	localparam int RATE_BITS = SPM_BITS + 11;
	localparam int D   = COORD_BITS + 2;     // target and delta width
	localparam int DS  = D + 1;              // dx+dy and dx-dy
	localparam int PW  = DS + SPM_BITS + 1;  // A/B step product
	localparam int PZW = D + SPM_BITS + 1;   // Z step product
	localparam int FW  = FEED_BITS + SPM_BITS;
	// floor(x/60) = (x * ceil(2^K/60)) >> K holds exactly for x < 2^FW
	localparam int K   = FW + 6;
	localparam int MW  = K - 5;
	localparam int QW  = FW + MW;
	localparam logic [63:0] RECIP60 = ((64'd1 << K) + 64'd59) / 64'd60;

	// architectural state
	logic [COORD_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [2:0]            mode_q, flags_q, pend_q;
	logic                  res_valid_q;

	// result register
	logic [1:0]                  status_q;
	logic [2:0]                  ctrl_state_q;
	logic signed [STEP_BITS-1:0] steps_a_q, steps_b_q, steps_z_q;
	logic [RATE_BITS-1:0]        rate_a_q, rate_b_q, rate_z_q;
	logic [1:0]                  home_motor_q;
	logic                        stop_all_q, complete_q, complete_ok_q;

	// datapath
	logic signed [D-1:0]   c_v [3];
	logic signed [D-1:0]   p_v [3];
	logic signed [D-1:0]   m_v [3];
	logic signed [D-1:0]   t_v [3];
	logic signed [D-1:0]   d_v [3];
	logic                  inb;
	logic signed [DS-1:0]  dsum, ddif;
	logic signed [PW-1:0]  pa, pb, pa_adj, pb_adj, sa_full, sb_full;
	logic signed [PZW-1:0] pz, pz_adj, sz_full;
	logic                  nz_a, nz_b, nz_z;
	logic [QW-1:0]         qa, qb, qz;
	logic [RATE_BITS-1:0]  ra, rb, rz;

	// next state and result
	logic [COORD_BITS-1:0] n_pos_x, n_pos_y, n_pos_z;
	logic [2:0]            n_mode, n_flags, n_pend;
	logic [1:0]            n_status, n_hm;
	logic                  n_stop, n_done, n_done_ok;
	logic signed [STEP_BITS-1:0] n_sa, n_sb, n_sz;
	logic [RATE_BITS-1:0]  n_ra, n_rb, n_rz;
	logic [2:0]            sel_bit;
	logic                  home_hit;
	home_step_t            hs_home, hs_done;

	assign advance = valid_s1 && (!res_valid_q || res.ready);

	// targets, deltas and bounds
	always_comb begin
		c_v[0] = D'(coord_x_s1);
		c_v[1] = D'(coord_y_s1);
		c_v[2] = D'(coord_z_s1);
		p_v[0] = $signed({2'b00, pos_x_q});
		p_v[1] = $signed({2'b00, pos_y_q});
		p_v[2] = $signed({2'b00, pos_z_q});
		m_v[0] = $signed({2'b00, max_x});
		m_v[1] = $signed({2'b00, max_y});
		m_v[2] = $signed({2'b00, max_z});
		inb = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (mask_s1[i]) begin
				t_v[i] = relative_mode ? p_v[i] + c_v[i] : c_v[i];
				d_v[i] = relative_mode ? c_v[i] : c_v[i] - p_v[i];
			end else begin
				t_v[i] = p_v[i];
				d_v[i] = '0;
			end
			if (t_v[i] < 0 || t_v[i] > m_v[i])
				inb = 1'b0;
		end
	end

	// step counts, /256 truncated toward zero
	always_comb begin
		dsum    = DS'(d_v[0]) + DS'(d_v[1]);
		ddif    = DS'(d_v[0]) - DS'(d_v[1]);
		pa      = PW'(dsum) * PW'($signed({1'b0, spm_a}));
		pb      = PW'(ddif) * PW'($signed({1'b0, spm_b}));
		pz      = PZW'(d_v[2]) * PZW'($signed({1'b0, spm_z}));
		pa_adj  = pa + (pa[PW-1] ? PW'(255) : PW'(0));
		pb_adj  = pb + (pb[PW-1] ? PW'(255) : PW'(0));
		pz_adj  = pz + (pz[PZW-1] ? PZW'(255) : PZW'(0));
		sa_full = pa_adj >>> 8;
		sb_full = pb_adj >>> 8;
		sz_full = pz_adj >>> 8;
		nz_a    = (sa_full != '0);
		nz_b    = (sb_full != '0);
		nz_z    = (sz_full != '0);
	end

	// step rates: divide feed * spm by 60
	always_comb begin
		qa = QW'(prod_a_s1) * QW'(RECIP60[MW-1:0]);
		qb = QW'(prod_b_s1) * QW'(RECIP60[MW-1:0]);
		qz = QW'(prod_z_s1) * QW'(RECIP60[MW-1:0]);
		ra = qa[K +: RATE_BITS];
		rb = qb[K +: RATE_BITS];
		rz = qz[K +: RATE_BITS];
	end

	assign hs_home = next_home(mask_s1);
	assign hs_done = next_home(pend_q);
	assign home_hit = (mode_q == MODE_HOME_Z && sel_s1 == MSEL_Z) ||
		(mode_q == MODE_HOME_X && sel_s1 == MSEL_A) ||
		(mode_q == MODE_HOME_Y && sel_s1 == MSEL_B);

	always_comb begin
		case (sel_s1)
			MSEL_A:  sel_bit = 3'b001;
			MSEL_B:  sel_bit = 3'b010;
			MSEL_Z:  sel_bit = 3'b100;
			default: sel_bit = 3'b000;
		endcase
	end

	always_comb begin
		n_pos_x   = pos_x_q;
		n_pos_y   = pos_y_q;
		n_pos_z   = pos_z_q;
		n_mode    = mode_q;
		n_flags   = flags_q;
		n_pend    = pend_q;
		n_status  = ST_ACCEPT;
		n_hm      = HM_NONE;
		n_stop    = 1'b0;
		n_done    = 1'b0;
		n_done_ok = 1'b0;
		n_sa      = '0;
		n_sb      = '0;
		n_sz      = '0;
		n_ra      = '0;
		n_rb      = '0;
		n_rz      = '0;
		case (func_s1)
			FUNC_MOVE: begin
				if (mask_s1 != '0) begin
					if (mode_q != MODE_IDLE) begin
						n_status = ST_BUSY;
					end else if (!inb) begin
						n_status = ST_OOB;
					end else begin
						n_pos_x = t_v[0][COORD_BITS-1:0];
						n_pos_y = t_v[1][COORD_BITS-1:0];
						n_pos_z = t_v[2][COORD_BITS-1:0];
						n_sa    = sa_full[STEP_BITS-1:0];
						n_sb    = sb_full[STEP_BITS-1:0];
						n_sz    = sz_full[STEP_BITS-1:0];
						n_ra    = nz_a ? ra : '0;
						n_rb    = nz_b ? rb : '0;
						n_rz    = nz_z ? rz : '0;
						n_flags = {!nz_z, !nz_b, !nz_a};
						if (n_flags == FLAGS_ALL) begin
							n_done    = 1'b1;
							n_done_ok = 1'b1;
						end else begin
							n_mode = MODE_MOVING;
						end
					end
				end
			end
			FUNC_HOME: begin
				if (mode_q != MODE_IDLE) begin
					n_status = ST_BUSY;
				end else begin
					n_pend = hs_home.pend;
					n_mode = hs_home.mode;
					n_hm   = hs_home.hm;
					if (hs_home.hm == HM_NONE) begin
						n_done    = 1'b1;
						n_done_ok = 1'b1;
					end
				end
			end
			FUNC_DONE: begin
				if (sel_s1 != MSEL_NONE) begin
					n_flags = flags_q | sel_bit;
					if (!ok_s1) begin
						n_stop = 1'b1;
						n_done = (mode_q != MODE_IDLE);
						n_mode = MODE_IDLE;
						n_pend = '0;
					end else if (mode_q == MODE_MOVING) begin
						if (n_flags == FLAGS_ALL) begin
							n_mode    = MODE_IDLE;
							n_done    = 1'b1;
							n_done_ok = 1'b1;
						end
					end else if (home_hit) begin
						// zero the homed axis and start the next one
						if (sel_s1 == MSEL_Z)
							n_pos_z = '0;
						else if (sel_s1 == MSEL_A)
							n_pos_x = '0;
						else
							n_pos_y = '0;
						n_pend = hs_done.pend;
						n_mode = hs_done.mode;
						n_hm   = hs_done.hm;
						if (hs_done.hm == HM_NONE) begin
							n_done    = 1'b1;
							n_done_ok = 1'b1;
						end
					end
				end
			end
			FUNC_STOP: begin
				n_stop = 1'b1;
				n_done = (mode_q != MODE_IDLE);
				n_mode = MODE_IDLE;
				n_pend = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			pos_z_q     <= '0;
			mode_q      <= MODE_IDLE;
			flags_q     <= '0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pos_x_q     <= n_pos_x;
				pos_y_q     <= n_pos_y;
				pos_z_q     <= n_pos_z;
				mode_q      <= n_mode;
				flags_q     <= n_flags;
				pend_q      <= n_pend;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= n_status;
			ctrl_state_q  <= n_mode;
			steps_a_q     <= n_sa;
			steps_b_q     <= n_sb;
			steps_z_q     <= n_sz;
			rate_a_q      <= n_ra;
			rate_b_q      <= n_rb;
			rate_z_q      <= n_rz;
			home_motor_q  <= n_hm;
			stop_all_q    <= n_stop;
			complete_q    <= n_done;
			complete_ok_q <= n_done_ok;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.ctrl_state  = ctrl_state_q;
	assign res.steps_a     = steps_a_q;
	assign res.steps_b     = steps_b_q;
	assign res.steps_z     = steps_z_q;
	assign res.rate_a      = rate_a_q;
	assign res.rate_b      = rate_b_q;
	assign res.rate_z      = rate_z_q;
	assign res.home_motor  = home_motor_q;
	assign res.stop_all    = stop_all_q;
	assign res.complete    = complete_q;
	assign res.complete_ok = complete_ok_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_IDLE) |-> (pend_q == '0))
		else $error("homing axes pending while idle");

	a_moving_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_MOVING) |-> (flags_q != FLAGS_ALL))
		else $error("moving with every motor already done");

	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("request taken but no result registered");

	a_steps_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (steps_a_q != '0 || steps_b_q != '0 || steps_z_q != '0))
		|-> (status_q == ST_ACCEPT && ctrl_state_q == MODE_MOVING))
		else $error("steps issued without an accepted move");

endmodule

/* hw/rtl/corexy_motion_command_controller.sv */
// ----------------------------------------------------------------------------
// corexy_motion_command_controller
// CoreXY move and homing controller with bounds check, step counts and rates.
//
//   channel  dir  handshake          carries
//   cmd      in   valid/ready        move, home, motor done, stop request
//   res      out  valid/ready        status, mode, steps, rates, homing cmd
//   apb      in   psel/penable/...   mode, bounds, steps per mm
//
// One request per cycle is sustained while results are not stalled; each
// request passes the input register, then the result register.
// The result register decouples the two sides: a stalled result holds while
// one more request waits in the input register.
// arst_n clears position, mode, motor flags, pending homing axes and the
// feedrate (to 1000 mm/min); registers return to their reset values.
// ----------------------------------------------------------------------------
module corexy_motion_command_controller
	import cxy_pkg::*;
#(
	parameter int COORD_BITS = 23,
	parameter int SPM_BITS   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	cxy_cmd_if.sink     cmd,
	cxy_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FW = FEED_BITS + SPM_BITS;

	logic                  relative_mode;
	logic [COORD_BITS-1:0] max_x, max_y, max_z;
	logic [SPM_BITS-1:0]   spm_a, spm_b, spm_z;

	logic                       advance;
	logic                       valid_s1;
	logic [1:0]                 func_s1;
	logic signed [COORD_BITS:0] coord_x_s1, coord_y_s1, coord_z_s1;
	logic [2:0]                 mask_s1;
	logic [1:0]                 sel_s1;
	logic                       ok_s1;
	logic [FW-1:0]              prod_a_s1, prod_b_s1, prod_z_s1;

	cxy_cfg_regs #(
		.COORD_BITS (COORD_BITS),
		.SPM_BITS   (SPM_BITS)
	) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.relative_mode (relative_mode),
		.max_x         (max_x),
		.max_y         (max_y),
		.max_z         (max_z),
		.spm_a         (spm_a),
		.spm_b         (spm_b),
		.spm_z         (spm_z)
	);

	cxy_cmd_stage #(
		.COORD_BITS (COORD_BITS),
		.SPM_BITS   (SPM_BITS)
	) u_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.spm_a      (spm_a),
		.spm_b      (spm_b),
		.spm_z      (spm_z),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.func_s1    (func_s1),
		.coord_x_s1 (coord_x_s1),
		.coord_y_s1 (coord_y_s1),
		.coord_z_s1 (coord_z_s1),
		.mask_s1    (mask_s1),
		.sel_s1     (sel_s1),
		.ok_s1      (ok_s1),
		.prod_a_s1  (prod_a_s1),
		.prod_b_s1  (prod_b_s1),
		.prod_z_s1  (prod_z_s1)
	);

	cxy_exec #(
		.COORD_BITS (COORD_BITS),
		.SPM_BITS   (SPM_BITS)
	) u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.func_s1       (func_s1),
		.coord_x_s1    (coord_x_s1),
		.coord_y_s1    (coord_y_s1),
		.coord_z_s1    (coord_z_s1),
		.mask_s1       (mask_s1),
		.sel_s1        (sel_s1),
		.ok_s1         (ok_s1),
		.prod_a_s1     (prod_a_s1),
		.prod_b_s1     (prod_b_s1),
		.prod_z_s1     (prod_z_s1),
		.relative_mode (relative_mode),
		.max_x         (max_x),
		.max_y         (max_y),
		.max_z         (max_z),
		.spm_a         (spm_a),
		.spm_b         (spm_b),
		.spm_z         (spm_z),
		.advance       (advance),
		.res           (res)
	);

endmodule

/* tb/tb_corexy_motion_command_controller.sv */
// ----------------------------------------------------------------------------
// tb_corexy_motion_command_controller
// Self-checking bench for the CoreXY move and homing controller. A directed
// table covers the edge cases: empty moves and homes, busy and out-of-range
// rejections, zero-step moves, failed motors, stops and the Z, X, Y homing
// order. Random phases follow, each under its own register setting. Most
// random requests are well-formed moves and homing runs that are followed
// by the motor-done events they need; the rest are noise. Each result is
// checked field by field against an in-bench model of the controller.
// ----------------------------------------------------------------------------
module tb_corexy_motion_command_controller;
	timeunit 1ns;
	timeprecision 1ps;

	import cxy_pkg::*;

	localparam int COORD_BITS = 23;
	localparam int SPM_BITS   = 12;
	localparam int STEP_BITS  = COORD_BITS + SPM_BITS - 6;
	localparam int RATE_BITS  = SPM_BITS + 11;
	localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
	localparam int SPM_MAX    = (1 << SPM_BITS) - 1;

	typedef struct packed {
		logic [1:0]                func;
		logic signed [COORD_BITS:0] coord_x;
		logic signed [COORD_BITS:0] coord_y;
		logic signed [COORD_BITS:0] coord_z;
		logic [2:0]                axis_mask;
		logic [15:0]               feedrate;
		logic [1:0]                motor_sel;
		logic                      motor_ok;
	} motion_cmd_t;

	typedef struct packed {
		logic [1:0]                  status;
		logic [2:0]                  ctrl_state;
		logic signed [STEP_BITS-1:0] steps_a;
		logic signed [STEP_BITS-1:0] steps_b;
		logic signed [STEP_BITS-1:0] steps_z;
		logic [RATE_BITS-1:0]        rate_a;
		logic [RATE_BITS-1:0]        rate_b;
		logic [RATE_BITS-1:0]        rate_z;
		logic [1:0]                  home_motor;
		logic                        stop_all;
		logic                        complete;
		logic                        complete_ok;
	} motion_res_t;

	typedef struct packed {
		motion_cmd_t c;
		logic        pin;
		logic [1:0]  want_status;
		logic [2:0]  want_state;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	cxy_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
	cxy_res_if #(.COORD_BITS(COORD_BITS), .SPM_BITS(SPM_BITS)) res_ch ();

	corexy_motion_command_controller #(
		.COORD_BITS(COORD_BITS),
		.SPM_BITS  (SPM_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// controller model: registers
	logic                  rel_on;
	logic [COORD_BITS-1:0] lim_x, lim_y, lim_z;
	logic [SPM_BITS-1:0]   per_mm_a, per_mm_b, per_mm_z;
	// controller model: state
	logic [COORD_BITS-1:0] at_x, at_y, at_z;
	logic [2:0]            ctl_mode;
	logic [2:0]            motor_flags;
	logic [15:0]           feed_now;
	logic [2:0]            axes_left;

	motion_res_t awaited_results [$];
	plan_row_t   plan [$];
	int          fail_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic clear_model();
		rel_on      = 1'b0;
		lim_x       = COORD_BITS'(MAX_XY_RESET);
		lim_y       = COORD_BITS'(MAX_XY_RESET);
		lim_z       = COORD_BITS'(MAX_Z_RESET);
		per_mm_a    = SPM_BITS'(SPM_XY_RESET);
		per_mm_b    = SPM_BITS'(SPM_XY_RESET);
		per_mm_z    = SPM_BITS'(SPM_Z_RESET);
		at_x        = '0;
		at_y        = '0;
		at_z        = '0;
		ctl_mode    = MODE_IDLE;
		motor_flags = '0;
		feed_now    = FEED_RESET;
		axes_left   = '0;
	endtask

	// take the next axis still to home (Z, then X, then Y), or drop to idle
	function automatic logic [1:0] start_next_axis();
		logic [1:0] hm;
		hm       = HM_NONE;
		ctl_mode = MODE_IDLE;
		if (axes_left[2]) begin
			axes_left[2] = 1'b0;
			ctl_mode     = MODE_HOME_Z;
			hm           = HM_Z;
		end else if (axes_left[0]) begin
			axes_left[0] = 1'b0;
			ctl_mode     = MODE_HOME_X;
			hm           = HM_A;
		end else if (axes_left[1]) begin
			axes_left[1] = 1'b0;
			ctl_mode     = MODE_HOME_Y;
			hm           = HM_B;
		end
		return hm;
	endfunction

	function automatic motion_res_t predict_motion(input motion_cmd_t c);
		motion_res_t r;
		longint      off [3];
		longint      cur [3];
		longint      lim [3];
		longint      tgt [3];
		longint      sa, sb, sz, ra, rb, rz;
		logic        in_range;
		logic        axis_match;
		r = '0;
		r.status = ST_ACCEPT;
		case (c.func)
		FUNC_MOVE: begin
			if (c.feedrate != 0)
				feed_now = c.feedrate;
			if (c.axis_mask != 0) begin
				if (ctl_mode != MODE_IDLE) begin
					r.status = ST_BUSY;
				end else begin
					off[0] = longint'(c.coord_x);
					off[1] = longint'(c.coord_y);
					off[2] = longint'(c.coord_z);
					cur[0] = longint'(at_x);
					cur[1] = longint'(at_y);
					cur[2] = longint'(at_z);
					lim[0] = longint'(lim_x);
					lim[1] = longint'(lim_y);
					lim[2] = longint'(lim_z);
					in_range = 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (c.axis_mask[i])
							tgt[i] = rel_on ? cur[i] + off[i] : off[i];
						else
							tgt[i] = cur[i];
						if (tgt[i] < 0 || tgt[i] > lim[i])
							in_range = 1'b0;
					end
					if (!in_range) begin
						r.status = ST_OOB;
					end else begin
						// signed division truncates toward zero
						sa = ((tgt[0] - cur[0]) + (tgt[1] - cur[1])) * longint'(per_mm_a) / 256;
						sb = ((tgt[0] - cur[0]) - (tgt[1] - cur[1])) * longint'(per_mm_b) / 256;
						sz = (tgt[2] - cur[2]) * longint'(per_mm_z) / 256;
						ra = longint'(feed_now) * longint'(per_mm_a) / 60;
						rb = longint'(feed_now) * longint'(per_mm_b) / 60;
						rz = longint'(feed_now) * longint'(per_mm_z) / 60;
						at_x = tgt[0][COORD_BITS-1:0];
						at_y = tgt[1][COORD_BITS-1:0];
						at_z = tgt[2][COORD_BITS-1:0];
						r.steps_a = sa[STEP_BITS-1:0];
						r.steps_b = sb[STEP_BITS-1:0];
						r.steps_z = sz[STEP_BITS-1:0];
						motor_flags = '0;
						if (sa != 0) r.rate_a = ra[RATE_BITS-1:0]; else motor_flags[0] = 1'b1;
						if (sb != 0) r.rate_b = rb[RATE_BITS-1:0]; else motor_flags[1] = 1'b1;
						if (sz != 0) r.rate_z = rz[RATE_BITS-1:0]; else motor_flags[2] = 1'b1;
						if (motor_flags == FLAGS_ALL) begin
							r.complete    = 1'b1;
							r.complete_ok = 1'b1;
						end else begin
							ctl_mode = MODE_MOVING;
						end
					end
				end
			end
		end
		FUNC_HOME: begin
			if (ctl_mode != MODE_IDLE) begin
				r.status = ST_BUSY;
			end else begin
				axes_left    = c.axis_mask;
				r.home_motor = start_next_axis();
				if (r.home_motor == HM_NONE) begin
					r.complete    = 1'b1;
					r.complete_ok = 1'b1;
				end
			end
		end
		FUNC_DONE: begin
			if (c.motor_sel != MSEL_NONE) begin
				motor_flags[c.motor_sel] = 1'b1;
				axis_match = (ctl_mode == MODE_HOME_Z && c.motor_sel == MSEL_Z) ||
					(ctl_mode == MODE_HOME_X && c.motor_sel == MSEL_A) ||
					(ctl_mode == MODE_HOME_Y && c.motor_sel == MSEL_B);
				if (!c.motor_ok) begin
					r.stop_all = 1'b1;
					if (ctl_mode != MODE_IDLE)
						r.complete = 1'b1;
					ctl_mode  = MODE_IDLE;
					axes_left = '0;
				end else if (ctl_mode == MODE_MOVING) begin
					if (motor_flags == FLAGS_ALL) begin
						ctl_mode      = MODE_IDLE;
						r.complete    = 1'b1;
						r.complete_ok = 1'b1;
					end
				end else if (axis_match) begin
					if (c.motor_sel == MSEL_Z) at_z = '0;
					else if (c.motor_sel == MSEL_A) at_x = '0;
					else at_y = '0;
					r.home_motor = start_next_axis();
					if (r.home_motor == HM_NONE) begin
						r.complete    = 1'b1;
						r.complete_ok = 1'b1;
					end
				end
			end
		end
		default: begin
			r.stop_all = 1'b1;
			if (ctl_mode != MODE_IDLE)
				r.complete = 1'b1;
			ctl_mode  = MODE_IDLE;
			axes_left = '0;
		end
		endcase
		r.ctrl_state = ctl_mode;
		return r;
	endfunction

	// coordinate that lands an axis on a target, mostly inside the bounds
	function automatic logic signed [COORD_BITS:0] aim(input logic [COORD_BITS-1:0] lim,
			input logic [COORD_BITS-1:0] cur);
		longint t;
		case ($urandom_range(0, 9))
		0: t = 0;
		1: t = longint'(lim);
		2: t = longint'(cur) + longint'($urandom_range(0, 64)) - 32;
		3: t = longint'(lim) + 1 + longint'($urandom_range(0, 99));
		4: t = -1 - longint'($urandom_range(0, 99));
		default: t = longint'($urandom_range(0, lim));
		endcase
		if (rel_on)
			t = t - longint'(cur);
		return t[COORD_BITS:0];
	endfunction

	function automatic motion_cmd_t pick_command();
		motion_cmd_t c;
		int          roll;
		logic [1:0]  s;
		c.func      = FUNC_MOVE;
		c.coord_x   = (COORD_BITS+1)'($urandom);
		c.coord_y   = (COORD_BITS+1)'($urandom);
		c.coord_z   = (COORD_BITS+1)'($urandom);
		c.axis_mask = 3'($urandom_range(0, 7));
		c.feedrate  = '0;
		if ($urandom_range(0, 2) != 0)
			c.feedrate = 16'($urandom);
		c.motor_sel = 2'($urandom_range(0, 3));
		c.motor_ok  = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 8) begin
			c.func = 2'($urandom_range(0, 3));
		end else if (ctl_mode == MODE_IDLE) begin
			if (roll < 60) begin
				c.func      = FUNC_MOVE;
				c.axis_mask = 3'($urandom_range(1, 7));
				c.coord_x   = aim(lim_x, at_x);
				c.coord_y   = aim(lim_y, at_y);
				c.coord_z   = aim(lim_z, at_z);
			end else if (roll < 80) begin
				c.func = FUNC_HOME;
			end else if (roll < 92) begin
				c.func = FUNC_DONE;
			end else begin
				c.func = FUNC_STOP;
			end
		end else if (roll < 80) begin
			// finish a motor that the running action still waits on
			c.func     = FUNC_DONE;
			c.motor_ok = ($urandom_range(0, 19) != 0);
			if (ctl_mode == MODE_MOVING) begin
				do s = 2'($urandom_range(0, 2)); while (motor_flags[s]);
				c.motor_sel = s;
			end else if (ctl_mode == MODE_HOME_Z) begin
				c.motor_sel = MSEL_Z;
			end else if (ctl_mode == MODE_HOME_X) begin
				c.motor_sel = MSEL_A;
			end else begin
				c.motor_sel = MSEL_B;
			end
		end else if (roll < 88) begin
			c.func = FUNC_DONE;
		end else if (roll < 94) begin
			c.func = ($urandom_range(0, 1) != 0) ? FUNC_HOME : FUNC_MOVE;
		end else begin
			c.func = FUNC_STOP;
		end
		return c;
	endfunction

	task automatic add_row(input logic [1:0] f, input int x, input int y, input int z,
			input logic [2:0] mask, input int feed, input logic [1:0] sel, input logic ok,
			input logic pin, input logic [1:0] st, input logic [2:0] state);
		plan_row_t r;
		r.c.func      = f;
		r.c.coord_x   = (COORD_BITS+1)'(x);
		r.c.coord_y   = (COORD_BITS+1)'(y);
		r.c.coord_z   = (COORD_BITS+1)'(z);
		r.c.axis_mask = mask;
		r.c.feedrate  = 16'(feed);
		r.c.motor_sel = sel;
		r.c.motor_ok  = ok;
		r.pin         = pin;
		r.want_status = st;
		r.want_state  = state;
		plan.push_back(r);
	endtask

	task automatic send_command(input motion_cmd_t c, input int gap, output motion_res_t pred);
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid     <= 1'b1;
		cmd_ch.func      <= c.func;
		cmd_ch.coord_x   <= c.coord_x;
		cmd_ch.coord_y   <= c.coord_y;
		cmd_ch.coord_z   <= c.coord_z;
		cmd_ch.axis_mask <= c.axis_mask;
		cmd_ch.feedrate  <= c.feedrate;
		cmd_ch.motor_sel <= c.motor_sel;
		cmd_ch.motor_ok  <= c.motor_ok;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		pred = predict_motion(c);
		awaited_results.push_back(pred);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		case (idx)
		REG_REL:   rel_on   = val[0];
		REG_MAX_X: lim_x    = val[COORD_BITS-1:0];
		REG_MAX_Y: lim_y    = val[COORD_BITS-1:0];
		REG_MAX_Z: lim_z    = val[COORD_BITS-1:0];
		REG_SPM_A: per_mm_a = val[SPM_BITS-1:0];
		REG_SPM_B: per_mm_b = val[SPM_BITS-1:0];
		REG_SPM_Z: per_mm_z = val[SPM_BITS-1:0];
		default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_settings(input int rel, input int mx, input int my, input int mz,
			input int sa, input int sb, input int sz);
		write_reg(REG_REL, rel);
		write_reg(REG_MAX_X, mx);
		write_reg(REG_MAX_Y, my);
		write_reg(REG_MAX_Z, mz);
		write_reg(REG_SPM_A, sa);
		write_reg(REG_SPM_B, sb);
		write_reg(REG_SPM_Z, sz);
	endtask

	task automatic wait_drain();
		int spin;
		spin = 0;
		while (awaited_results.size() != 0 && spin < 5000) begin
			@(posedge clk);
			spin++;
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_result();
		motion_res_t want;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result, status %0d state %0d", $time,
				res_ch.status, res_ch.ctrl_state);
			fail_count++;
		end else begin
			want = awaited_results.pop_front();
			check_field("status", 64'(want.status), 64'(res_ch.status));
			check_field("ctrl_state", 64'(want.ctrl_state), 64'(res_ch.ctrl_state));
			check_field("steps_a", 64'($signed(want.steps_a)), 64'($signed(res_ch.steps_a)));
			check_field("steps_b", 64'($signed(want.steps_b)), 64'($signed(res_ch.steps_b)));
			check_field("steps_z", 64'($signed(want.steps_z)), 64'($signed(res_ch.steps_z)));
			check_field("rate_a", 64'(want.rate_a), 64'(res_ch.rate_a));
			check_field("rate_b", 64'(want.rate_b), 64'(res_ch.rate_b));
			check_field("rate_z", 64'(want.rate_z), 64'(res_ch.rate_z));
			check_field("home_motor", 64'(want.home_motor), 64'(res_ch.home_motor));
			check_field("stop_all", 64'(want.stop_all), 64'(res_ch.stop_all));
			check_field("complete", 64'(want.complete), 64'(res_ch.complete));
			check_field("complete_ok", 64'(want.complete_ok), 64'(res_ch.complete_ok));
		end
	endtask

	// result side: stall at random, with stretches of none
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		res_ch.ready = 1'b0;
		forever begin
			stall = ((taken % 90) >= 70) ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				@(negedge clk);
				res_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			taken++;
			check_result();
		end
	end

	initial begin : stimulus
		motion_res_t pred;
		motion_cmd_t cmd;
		int          gap;
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.func      = FUNC_MOVE;
		cmd_ch.coord_x   = '0;
		cmd_ch.coord_y   = '0;
		cmd_ch.coord_z   = '0;
		cmd_ch.axis_mask = '0;
		cmd_ch.feedrate  = '0;
		cmd_ch.motor_sel = MSEL_A;
		cmd_ch.motor_ok  = 1'b0;
		clear_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		//      func       x         y      z         mask feed   sel        ok pin status    state
		add_row(FUNC_MOVE, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_NONE, 1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_STOP, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_HOME, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_MOVE, 56320,    0,     64000,    7,   65535, MSEL_A,    1, 1, ST_ACCEPT, MODE_MOVING);
		add_row(FUNC_MOVE, 0,        0,     0,        1,   0,     MSEL_A,    1, 1, ST_BUSY,   MODE_MOVING);
		add_row(FUNC_HOME, 0,        0,     0,        7,   0,     MSEL_A,    1, 1, ST_BUSY,   MODE_MOVING);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_A,    1, 0, ST_ACCEPT, MODE_MOVING);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_B,    1, 0, ST_ACCEPT, MODE_MOVING);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_Z,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_MOVE, -1,       0,     0,        1,   0,     MSEL_A,    1, 1, ST_OOB,    MODE_IDLE);
		add_row(FUNC_MOVE, 56321,    0,     0,        1,   0,     MSEL_A,    1, 1, ST_OOB,    MODE_IDLE);
		add_row(FUNC_MOVE, 0,        56320, 0,        2,   1,     MSEL_A,    1, 1, ST_ACCEPT, MODE_MOVING);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_A,    0, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_MOVE, 56320,    56320, 64000,    7,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_MOVE, 0,        0,     -8388608, 4,   0,     MSEL_A,    1, 1, ST_OOB,    MODE_IDLE);
		add_row(FUNC_MOVE, 0,        0,     8388607,  4,   0,     MSEL_A,    1, 1, ST_OOB,    MODE_IDLE);
		add_row(FUNC_HOME, 0,        0,     0,        7,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_HOME_Z);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_HOME_Z);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_Z,    1, 1, ST_ACCEPT, MODE_HOME_X);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_HOME_Y);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_B,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_HOME, 0,        0,     0,        3,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_HOME_X);
		add_row(FUNC_STOP, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_DONE, 0,        0,     0,        0,   0,     MSEL_Z,    0, 1, ST_ACCEPT, MODE_IDLE);
		add_row(FUNC_MOVE, 100,      200,   0,        3,   0,     MSEL_A,    1, 0, ST_ACCEPT, MODE_MOVING);
		add_row(FUNC_STOP, 0,        0,     0,        0,   0,     MSEL_A,    1, 1, ST_ACCEPT, MODE_IDLE);

		foreach (plan[i]) begin
			send_command(plan[i].c, $urandom_range(0, 9), pred);
			if (plan[i].pin && (pred.status !== plan[i].want_status ||
					pred.ctrl_state !== plan[i].want_state)) begin
				$display("%0t: row %0d expected status %0d state %0d, got %0d %0d", $time, i,
					plan[i].want_status, plan[i].want_state, pred.status, pred.ctrl_state);
				fail_count++;
			end
		end

		for (int phase = 0; phase < 5; phase++) begin
			// hold requests off until every result is back, then reprogram
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			wait_drain();
			case (phase)
			0: apply_settings(0, MAX_XY_RESET, MAX_XY_RESET, MAX_Z_RESET,
				SPM_XY_RESET, SPM_XY_RESET, SPM_Z_RESET);
			1: apply_settings(1, COORD_MAX, COORD_MAX, COORD_MAX, SPM_MAX, SPM_MAX, SPM_MAX);
			2: apply_settings(0, 0, 0, 0, 1, 1, 1);
			default: apply_settings($urandom_range(0, 1), $urandom_range(0, COORD_MAX),
				$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
				$urandom_range(1, SPM_MAX), $urandom_range(1, SPM_MAX),
				$urandom_range(1, SPM_MAX));
			endcase
			for (int n = 0; n < 80; n++) begin
				gap = (n >= 55 && n < 70) ? 0 : $urandom_range(0, 9);
				cmd = pick_command();
				send_command(cmd, gap, pred);
			end
		end

		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait_drain();
		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, awaited_results.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
